### rtl/fsfa_pkg.sv
// Shared types and constants for the fixed-step frame accumulator.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package fsfa_pkg;

   localparam int unsigned TIME_W = 63;
   localparam int unsigned WORD_W = 64;

   localparam logic [TIME_W-1:0] TIMESTEP_RESET = 63'd16666667;

   // The divider produces one quotient bit per cycle, the multiplier takes one
   // multiplier bit per cycle.
   localparam int unsigned DIV_STEPS  = TIME_W;
   localparam int unsigned MUL_STEPS  = WORD_W;
   localparam int unsigned STEP_CNT_W = 6;
   localparam logic [STEP_CNT_W-1:0] DIV_LAST = STEP_CNT_W'(DIV_STEPS - 1);
   localparam logic [STEP_CNT_W-1:0] MUL_LAST = STEP_CNT_W'(MUL_STEPS - 1);
   localparam logic [STEP_CNT_W-1:0] CNT_ONE  = STEP_CNT_W'(1);

   // Action codes carried by a request transaction.
   localparam logic [1:0] ACT_STEP    = 2'd0;
   localparam logic [1:0] ACT_ACCUM   = 2'd1;
   localparam logic [1:0] ACT_CONSUME = 2'd2;
   localparam logic [1:0] ACT_RESEED  = 2'd3;

   // Status codes carried by a response transaction.
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_FRAME_OVF = 2'd1;
   localparam logic [1:0] STS_SIM_OVF   = 2'd2;
   localparam logic [1:0] STS_ACC_OVF   = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIVIDE,
      S_DIV_DONE,
      S_MULTIPLY,
      S_MUL_DONE,
      S_FINISH
   } state_type;

   // What the datapath writes back into the architectural state on commit.
   typedef enum logic [2:0] {
      CMT_KEEP,
      CMT_CLEAR,
      CMT_CONSUME,
      CMT_STEP,
      CMT_ACCUM
   } commit_kind_type;

   typedef struct packed {
      logic            load_item;
      logic            div_start;
      logic            div_step;
      logic            mul_start;
      logic            mul_step;
      logic            commit;
      commit_kind_type kind;
      logic [1:0]      status;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       elapsed_skip;
      logic       acc_ovf;
      logic       cand_zero;
      logic       frame_ovf;
      logic       sim_ovf;
      logic       out_free;
   } dp_stat_type;

endpackage

### rtl/fsfa_if.sv
// Valid/ready channel interfaces for the fixed-step frame accumulator:
// request, response and timestep register write.
// Depends on fsfa_pkg.
interface fsfa_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     action;
   logic [fsfa_pkg::WORD_W-1:0]    frame_count_in;
   logic signed [fsfa_pkg::WORD_W-1:0] elapsed_ns;
   logic [fsfa_pkg::WORD_W-1:0]    new_seed;

   modport source (output valid, action, frame_count_in, elapsed_ns, new_seed,
                   input ready);
   modport sink (input valid, action, frame_count_in, elapsed_ns, new_seed,
                 output ready);
endinterface

interface fsfa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [fsfa_pkg::TIME_W-1:0] frames_available;
   logic [fsfa_pkg::WORD_W-1:0] frame_number;
   logic [fsfa_pkg::TIME_W-1:0] sim_time_ns;
   logic [fsfa_pkg::TIME_W-1:0] remainder_ns;
   logic [fsfa_pkg::WORD_W-1:0] seed_out;
   logic [1:0]                  status;

   modport source (output valid, frames_available, frame_number, sim_time_ns,
                   remainder_ns, seed_out, status, input ready);
   modport sink (input valid, frames_available, frame_number, sim_time_ns,
                 remainder_ns, seed_out, status, output ready);
endinterface

interface fsfa_csr_if;
   logic                        valid;
   logic                        ready;
   logic [fsfa_pkg::TIME_W-1:0] timestep_ns;

   modport source (output valid, timestep_ns, input ready);
   modport sink (input valid, timestep_ns, output ready);
endinterface

### rtl/fsfa_ctrl.sv
// Sequencing state machine of the fixed-step frame accumulator.
// Drives the datapath by command struct and reads its status struct.
// Depends on fsfa_pkg.
module fsfa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fsfa_pkg::dp_stat_type stat,
   output fsfa_pkg::dp_cmd_type  cmd
);

   fsfa_pkg::state_type                 state_ff, state_in;
   logic [fsfa_pkg::STEP_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [1:0]                          status_ff, status_in;
   fsfa_pkg::commit_kind_type           kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fsfa_pkg::S_IDLE;
         cnt_ff    <= '0;
         status_ff <= fsfa_pkg::STS_OK;
         kind_ff   <= fsfa_pkg::CMT_KEEP;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
         kind_ff   <= kind_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fsfa_pkg::S_IDLE: begin
            if (req_valid) state_in = fsfa_pkg::S_CHECK;
         end
         fsfa_pkg::S_CHECK: begin
            if (stat.action == fsfa_pkg::ACT_RESEED) begin
               state_in = fsfa_pkg::S_FINISH;
            end else if (stat.action == fsfa_pkg::ACT_STEP) begin
               if (stat.cand_zero || stat.frame_ovf) state_in = fsfa_pkg::S_FINISH;
               else state_in = fsfa_pkg::S_MULTIPLY;
            end else begin
               if (stat.elapsed_skip || stat.acc_ovf) state_in = fsfa_pkg::S_FINISH;
               else state_in = fsfa_pkg::S_DIVIDE;
            end
         end
         fsfa_pkg::S_DIVIDE: begin
            if (cnt_ff == fsfa_pkg::DIV_LAST) state_in = fsfa_pkg::S_DIV_DONE;
         end
         fsfa_pkg::S_DIV_DONE: begin
            if (stat.action == fsfa_pkg::ACT_CONSUME || stat.cand_zero || stat.frame_ovf) begin
               state_in = fsfa_pkg::S_FINISH;
            end else begin
               state_in = fsfa_pkg::S_MULTIPLY;
            end
         end
         fsfa_pkg::S_MULTIPLY: begin
            if (cnt_ff == fsfa_pkg::MUL_LAST) state_in = fsfa_pkg::S_MUL_DONE;
         end
         fsfa_pkg::S_MUL_DONE: begin
            state_in = fsfa_pkg::S_FINISH;
         end
         fsfa_pkg::S_FINISH: begin
            if (stat.out_free) state_in = fsfa_pkg::S_IDLE;
         end
         default: state_in = fsfa_pkg::S_IDLE;
      endcase
   end

   // Outputs, step counter and the commit plan.
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.kind      = kind_ff;
      cmd.status    = status_ff;
      cnt_in        = '0;
      status_in     = status_ff;
      kind_in       = kind_ff;
      unique case (state_ff)
         fsfa_pkg::S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
            status_in     = fsfa_pkg::STS_OK;
            kind_in       = fsfa_pkg::CMT_KEEP;
         end
         fsfa_pkg::S_CHECK: begin
            cmd.div_start = 1'b1;
            cmd.mul_start = 1'b1;
            if (stat.action == fsfa_pkg::ACT_RESEED) begin
               kind_in = fsfa_pkg::CMT_CLEAR;
            end else if (stat.action == fsfa_pkg::ACT_STEP) begin
               if (!stat.cand_zero && stat.frame_ovf) status_in = fsfa_pkg::STS_FRAME_OVF;
            end else begin
               if (!stat.elapsed_skip && stat.acc_ovf) status_in = fsfa_pkg::STS_ACC_OVF;
            end
         end
         fsfa_pkg::S_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + fsfa_pkg::CNT_ONE;
         end
         fsfa_pkg::S_DIV_DONE: begin
            cmd.mul_start = 1'b1;
            if (stat.action == fsfa_pkg::ACT_CONSUME || stat.cand_zero) begin
               kind_in = fsfa_pkg::CMT_CONSUME;
            end else if (stat.frame_ovf) begin
               // The remainder rolls back: nothing is written.
               status_in = fsfa_pkg::STS_FRAME_OVF;
            end
         end
         fsfa_pkg::S_MULTIPLY: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + fsfa_pkg::CNT_ONE;
         end
         fsfa_pkg::S_MUL_DONE: begin
            if (stat.sim_ovf) begin
               status_in = fsfa_pkg::STS_SIM_OVF;
            end else if (stat.action == fsfa_pkg::ACT_STEP) begin
               kind_in = fsfa_pkg::CMT_STEP;
            end else begin
               kind_in = fsfa_pkg::CMT_ACCUM;
            end
         end
         fsfa_pkg::S_FINISH: begin
            cmd.commit = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### rtl/fsfa_datapath.sv
// Datapath of the fixed-step frame accumulator: architectural state, timestep
// register, bit-serial divider and multiplier, and the response register.
// Depends on fsfa_pkg.
module fsfa_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  fsfa_pkg::dp_cmd_type                cmd,
   output fsfa_pkg::dp_stat_type               stat,
   input  logic [1:0]                          req_action,
   input  logic [fsfa_pkg::WORD_W-1:0]         req_frame_count_in,
   input  logic signed [fsfa_pkg::WORD_W-1:0]  req_elapsed_ns,
   input  logic [fsfa_pkg::WORD_W-1:0]         req_new_seed,
   input  logic                                csr_valid,
   input  logic [fsfa_pkg::TIME_W-1:0]         csr_timestep_ns,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fsfa_pkg::TIME_W-1:0]         rsp_frames_available,
   output logic [fsfa_pkg::WORD_W-1:0]         rsp_frame_number,
   output logic [fsfa_pkg::TIME_W-1:0]         rsp_sim_time_ns,
   output logic [fsfa_pkg::TIME_W-1:0]         rsp_remainder_ns,
   output logic [fsfa_pkg::WORD_W-1:0]         rsp_seed_out,
   output logic [1:0]                          rsp_status
);

   localparam int unsigned TW = fsfa_pkg::TIME_W;
   localparam int unsigned WW = fsfa_pkg::WORD_W;

   // Architectural state.
   logic [TW-1:0] ts_ff;
   logic [WW-1:0] fc_ff, fc_in;
   logic [TW-1:0] sim_ff, sim_in;
   logic [TW-1:0] rem_ff, rem_in;
   logic [WW-1:0] seed_ff, seed_in;

   // Latched request.
   logic [1:0]           action_ff;
   logic [WW-1:0]        count_ff;
   logic signed [WW-1:0] elapsed_ff;
   logic [WW-1:0]        new_seed_ff;

   // Shift-subtract divider and shift-add multiplier.
   logic [TW-1:0] div_rem_ff, div_rem_in;
   logic [TW-1:0] div_quo_ff, div_quo_in;
   logic [TW-1:0] mul_acc_ff, mul_acc_in;
   logic [WW-1:0] mul_opd_ff, mul_opd_in;
   logic          mul_ovf_ff, mul_ovf_in;

   // Response register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0] rsp_frames_ff;
   logic [WW-1:0] rsp_fc_ff;
   logic [TW-1:0] rsp_sim_ff;
   logic [TW-1:0] rsp_rem_ff;
   logic [WW-1:0] rsp_seed_ff;
   logic [1:0]    rsp_status_ff;

   logic [WW-1:0] el_sum;
   logic [WW-1:0] cand;
   logic [WW:0]   fc_sum;
   logic [WW-1:0] sim_sum;
   logic [WW-1:0] div_shift;
   logic [WW:0]   div_diff;
   logic          div_ge;
   logic [WW:0]   mul_sum;
   logic [TW-1:0] frames;
   logic          out_free;

   // Wall-time remainder plus elapsed time; the top bit flags accumulator overflow.
   assign el_sum = {1'b0, rem_ff} + {1'b0, elapsed_ff[TW-1:0]};

   // Frames to advance: the count for a step, the quotient for an accumulate.
   assign cand   = (action_ff == fsfa_pkg::ACT_ACCUM) ? {1'b0, div_quo_ff} : count_ff;
   assign fc_sum = {1'b0, fc_ff} + {1'b0, cand};

   // Simulated time plus count times timestep; a carry means the 63-bit range is exceeded.
   assign sim_sum = {1'b0, sim_ff} + {1'b0, mul_acc_ff};

   assign div_shift = {div_rem_ff, div_quo_ff[TW-1]};
   assign div_diff  = {1'b0, div_shift} - {2'b00, ts_ff};
   assign div_ge    = !div_diff[WW];

   assign mul_sum = {1'b0, mul_acc_ff, 1'b0} +
                    (mul_opd_ff[WW-1] ? {2'b00, ts_ff} : {(WW+1){1'b0}});

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stat.action       = action_ff;
      stat.elapsed_skip = elapsed_ff[WW-1] || (elapsed_ff == '0);
      stat.acc_ovf      = el_sum[WW-1];
      stat.cand_zero    = (cand == '0);
      stat.frame_ovf    = fc_sum[WW];
      stat.sim_ovf      = mul_ovf_ff || sim_sum[WW-1];
      stat.out_free     = out_free;
   end

   always_comb begin
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      if (cmd.div_start) begin
         div_rem_in = '0;
         div_quo_in = el_sum[TW-1:0];
      end else if (cmd.div_step) begin
         div_rem_in = div_ge ? div_diff[TW-1:0] : div_shift[TW-1:0];
         div_quo_in = {div_quo_ff[TW-2:0], div_ge};
      end
   end

   always_comb begin
      mul_acc_in = mul_acc_ff;
      mul_opd_in = mul_opd_ff;
      mul_ovf_in = mul_ovf_ff;
      if (cmd.mul_start) begin
         mul_acc_in = '0;
         mul_opd_in = cand;
         mul_ovf_in = 1'b0;
      end else if (cmd.mul_step) begin
         mul_acc_in = mul_sum[TW-1:0];
         mul_opd_in = {mul_opd_ff[WW-2:0], 1'b0};
         mul_ovf_in = mul_ovf_ff || mul_sum[WW] || mul_sum[WW-1];
      end
   end

   always_comb begin
      fc_in   = fc_ff;
      sim_in  = sim_ff;
      rem_in  = rem_ff;
      seed_in = seed_ff;
      frames  = '0;
      case (cmd.kind)
         fsfa_pkg::CMT_CLEAR: begin
            fc_in   = '0;
            sim_in  = '0;
            rem_in  = '0;
            seed_in = new_seed_ff;
         end
         fsfa_pkg::CMT_CONSUME: begin
            rem_in = div_rem_ff;
            frames = div_quo_ff;
         end
         fsfa_pkg::CMT_STEP: begin
            fc_in  = fc_sum[WW-1:0];
            sim_in = sim_sum[TW-1:0];
         end
         fsfa_pkg::CMT_ACCUM: begin
            fc_in  = fc_sum[WW-1:0];
            sim_in = sim_sum[TW-1:0];
            rem_in = div_rem_ff;
            frames = div_quo_ff;
         end
         default: begin
            frames = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff        <= fsfa_pkg::TIMESTEP_RESET;
         fc_ff        <= '0;
         sim_ff       <= '0;
         rem_ff       <= '0;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A zero timestep write is dropped so the divisor never becomes zero.
         if (csr_valid && csr_timestep_ns != '0) ts_ff <= csr_timestep_ns;
         if (cmd.commit) begin
            fc_ff   <= fc_in;
            sim_ff  <= sim_in;
            rem_ff  <= rem_in;
            seed_ff <= seed_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff   <= req_action;
         count_ff    <= req_frame_count_in;
         elapsed_ff  <= req_elapsed_ns;
         new_seed_ff <= req_new_seed;
      end
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      mul_acc_ff <= mul_acc_in;
      mul_opd_ff <= mul_opd_in;
      mul_ovf_ff <= mul_ovf_in;
      if (cmd.commit) begin
         rsp_frames_ff <= frames;
         rsp_fc_ff     <= fc_in;
         rsp_sim_ff    <= sim_in;
         rsp_rem_ff    <= rem_in;
         rsp_seed_ff   <= seed_in;
         rsp_status_ff <= cmd.status;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_frames_available = rsp_frames_ff;
   assign rsp_frame_number     = rsp_fc_ff;
   assign rsp_sim_time_ns      = rsp_sim_ff;
   assign rsp_remainder_ns     = rsp_rem_ff;
   assign rsp_seed_out         = rsp_seed_ff;
   assign rsp_status           = rsp_status_ff;

endmodule

### rtl/fixed_step_frame_accumulator_top.sv
// Top level of the fixed-step frame accumulator: controller plus datapath.
// Depends on fsfa_pkg, fsfa_if, fsfa_ctrl and fsfa_datapath.
//
//   Channel    Direction  Transaction carries
//   req_chan   in         action, frame_count_in, elapsed_ns, new_seed
//   rsp_chan   out        frames_available, frame_number, sim_time_ns,
//                         remainder_ns, seed_out, status
//   csr_chan   in         timestep_ns register write
//
// One request is worked on at a time. A reseed, an ignored request and one that
// fails an early overflow check go from the check state straight to the finish
// state; a consume runs the 63-step shift-subtract divider, a step the 64-step
// shift-add multiplier, and a full accumulate the divider and then the multiplier.
// A new request is accepted in the cycle after the previous response is loaded.
// Reset is synchronous and active high; it clears the counters and the seed and
// loads the default timestep of 16666667 ns.
// The response sits in an output register. While it waits for rsp_chan.ready
// the next request is still accepted and computed; only the final write-back
// waits for the register to free up, so no transaction is lost or repeated.
//
// The timestep register accepts a write on every cycle. Writes are expected
// only while the block is idle, and a write of zero leaves the register alone.
// Every overflow (frame counter, simulated time, or wall-time accumulator)
// is reported in status and leaves all state, the remainder included, as it
// was before the transaction.
module fixed_step_frame_accumulator_top (
   input logic        clock,
   input logic        reset,
   fsfa_req_if.sink   req_chan,
   fsfa_rsp_if.source rsp_chan,
   fsfa_csr_if.sink   csr_chan
);

   fsfa_pkg::dp_cmd_type  cmd;
   fsfa_pkg::dp_stat_type stat;
   logic                  req_ready;

   // The controller sequences each transaction through the check, divide and
   // multiply phases that its action needs and tells the datapath what to commit.
   fsfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the state, the arithmetic units and the response register.
   fsfa_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_action           (req_chan.action),
      .req_frame_count_in   (req_chan.frame_count_in),
      .req_elapsed_ns       (req_chan.elapsed_ns),
      .req_new_seed         (req_chan.new_seed),
      .csr_valid            (csr_chan.valid),
      .csr_timestep_ns      (csr_chan.timestep_ns),
      .rsp_valid            (rsp_chan.valid),
      .rsp_ready            (rsp_chan.ready),
      .rsp_frames_available (rsp_chan.frames_available),
      .rsp_frame_number     (rsp_chan.frame_number),
      .rsp_sim_time_ns      (rsp_chan.sim_time_ns),
      .rsp_remainder_ns     (rsp_chan.remainder_ns),
      .rsp_seed_out         (rsp_chan.seed_out),
      .rsp_status           (rsp_chan.status)
   );

   assign req_chan.ready = req_ready;

   // The register write path never stalls.
   assign csr_chan.ready = 1'b1;

endmodule

### test/tb_top.sv
// Self-checking testbench for fixed_step_frame_accumulator_top: a table of directed requests,
// then random requests after eight timestep writes, each response checked against a predictor.
// Depends on fsfa_pkg, the channel interfaces in fsfa_if and the RTL of the block.
module tb_top;

   localparam int unsigned TIME_W = fsfa_pkg::TIME_W;
   localparam int unsigned WORD_W = fsfa_pkg::WORD_W;
   // Largest value of the 63-bit time quantities.
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam int unsigned PHASES = 8;
   // In this phase neither side idles, so requests and responses run back to back.
   localparam int unsigned STEADY_PHASE = 4;
   localparam int unsigned RAND_PER_PHASE = 230;
   localparam int unsigned FAULT_PRINTS = 10;
   // The quiet limit is well above the length of a full accumulate and leaves
   // room for long random stalls on either side.
   localparam int unsigned QUIET_LIMIT = 3000;
   localparam int unsigned DRAIN_CYCLES = 150;
   localparam int unsigned CSR_SETTLE = 4;
   localparam int unsigned IDLE_PCT = 28;

   // One response transaction as the block reports it.
   typedef struct packed {
      logic [TIME_W-1:0] frames;
      logic [WORD_W-1:0] frame_no;
      logic [TIME_W-1:0] sim_time;
      logic [TIME_W-1:0] remainder;
      logic [WORD_W-1:0] seed;
      logic [1:0]        status;
   } frame_report_type;

   // One request transaction, with an optional expected response typed in by hand.
   typedef struct packed {
      logic [1:0]        action;
      logic [WORD_W-1:0] count;
      logic [WORD_W-1:0] elapsed;
      logic [WORD_W-1:0] seed;
      logic              typed;
      frame_report_type  want;
   } stim_row_type;

   logic clock;
   logic reset;

   fsfa_req_if req_bus ();
   fsfa_rsp_if rsp_bus ();
   fsfa_csr_if csr_bus ();

   fixed_step_frame_accumulator_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Predictor state: the block's counters and its timestep register.
   logic [TIME_W-1:0] step_ns     = fsfa_pkg::TIMESTEP_RESET;
   logic [WORD_W-1:0] frame_ctr   = '0;
   logic [TIME_W-1:0] sim_ns      = '0;
   logic [TIME_W-1:0] wall_rem_ns = '0;
   logic [WORD_W-1:0] seed_val    = '0;

   frame_report_type due_reports [$];
   logic [TIME_W-1:0] phase_step_ns [PHASES];

   bit          steady = 1'b0;
   int unsigned faults = 0;
   int unsigned responses_seen = 0;
   int unsigned quiet_cycles = 0;
   int unsigned action_seen [4];
   int unsigned status_seen [4];

   // The directed table runs at the reset timestep of 16666667 ns. Rows with a typed
   // expectation are the ones whose outcome is plain: ignored elapsed time, a zero count,
   // reseeds, a small accumulate and the overflow checks from a known state. Others use the predictor.
   stim_row_type directed_rows [21] = '{
      // Zero count and non-positive elapsed time leave everything at zero.
      '{fsfa_pkg::ACT_STEP,    64'd0, 64'd0, 64'd0, 1'b1,
        '{63'd0, 64'd0, 63'd0, 63'd0, 64'd0, fsfa_pkg::STS_OK}},
      '{fsfa_pkg::ACT_ACCUM,   64'd0, 64'd0, 64'd0, 1'b1,
        '{63'd0, 64'd0, 63'd0, 63'd0, 64'd0, fsfa_pkg::STS_OK}},
      '{fsfa_pkg::ACT_ACCUM,   64'd0, 64'h8000_0000_0000_0000, 64'd0, 1'b1,
        '{63'd0, 64'd0, 63'd0, 63'd0, 64'd0, fsfa_pkg::STS_OK}},
      '{fsfa_pkg::ACT_CONSUME, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b1,
        '{63'd0, 64'd0, 63'd0, 63'd0, 64'd0, fsfa_pkg::STS_OK}},
      '{fsfa_pkg::ACT_RESEED,  64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        '{63'd0, 64'd0, 63'd0, 63'd0, 64'hFFFF_FFFF_FFFF_FFFF, fsfa_pkg::STS_OK}},
      // The largest count passes the frame check but not the simulated time check.
      '{fsfa_pkg::ACT_STEP,    64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0, 1'b1,
        '{63'd0, 64'd0, 63'd0, 63'd0, 64'hFFFF_FFFF_FFFF_FFFF, fsfa_pkg::STS_SIM_OVF}},
      // Largest elapsed time fills simulated time as far as whole frames allow, then the accumulator
      // overflows and a single further step overflows simulated time.
      '{fsfa_pkg::ACT_ACCUM,   64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 1'b0, '0},
      '{fsfa_pkg::ACT_CONSUME, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 1'b0, '0},
      '{fsfa_pkg::ACT_STEP,    64'd1, 64'd0, 64'd0, 1'b0, '0},
      '{fsfa_pkg::ACT_RESEED,  64'd0, 64'd0, 64'd0, 1'b1,
        '{63'd0, 64'd0, 63'd0, 63'd0, 64'd0, fsfa_pkg::STS_OK}},
      '{fsfa_pkg::ACT_ACCUM,   64'd0, 64'(fsfa_pkg::TIMESTEP_RESET) * 3 + 5, 64'd0, 1'b1,
        '{63'd3, 64'd3, fsfa_pkg::TIMESTEP_RESET * 3, 63'd5, 64'd0, fsfa_pkg::STS_OK}},
      '{fsfa_pkg::ACT_CONSUME, 64'd0, 64'd16666662, 64'd0, 1'b0, '0},
      '{fsfa_pkg::ACT_STEP,    64'd2, 64'd0, 64'd0, 1'b0, '0},
      '{fsfa_pkg::ACT_RESEED,  64'd0, 64'd0, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1,
        '{63'd0, 64'd0, 63'd0, 63'd0, 64'hA5A5_5A5A_0F0F_F0F0, fsfa_pkg::STS_OK}},
      '{fsfa_pkg::ACT_STEP,    64'd1, 64'd0, 64'd0, 1'b0, '0},
      // With one frame counted, the largest count overflows the frame counter.
      '{fsfa_pkg::ACT_STEP,    64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0, 1'b1,
        '{63'd0, 64'd1, fsfa_pkg::TIMESTEP_RESET, 63'd0, 64'hA5A5_5A5A_0F0F_F0F0,
          fsfa_pkg::STS_FRAME_OVF}},
      // The division succeeds but the advance does not, so the remainder rolls back.
      '{fsfa_pkg::ACT_ACCUM,   64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 1'b0, '0},
      '{fsfa_pkg::ACT_STEP,    64'h8000_0000_0000_0000, 64'd0, 64'd0, 1'b0, '0},
      '{fsfa_pkg::ACT_CONSUME, 64'd0, 64'd1, 64'd0, 1'b0, '0},
      '{fsfa_pkg::ACT_ACCUM,   64'd0, 64'h4000_0000_0000_0000, 64'd0, 1'b0, '0},
      // Leave a remainder behind so the first lowered timestep has to divide it.
      '{fsfa_pkg::ACT_CONSUME, 64'd0, 64'd16666000, 64'd0, 1'b0, '0}
   };

   // Advance by a frame count; the counters change only when no overflow is found.
   function automatic logic [1:0] try_advance(input logic [WORD_W-1:0] count);
      logic [WORD_W-1:0] room;
      if (count == '0) return fsfa_pkg::STS_OK;
      if (count > ~frame_ctr) return fsfa_pkg::STS_FRAME_OVF;
      room = {1'b0, TIME_MAX - sim_ns} / {1'b0, step_ns};
      if (count > room) return fsfa_pkg::STS_SIM_OVF;
      frame_ctr = frame_ctr + count;
      sim_ns = TIME_W'({1'b0, sim_ns} + {1'b0, step_ns} * count);
      return fsfa_pkg::STS_OK;
   endfunction

   // Add elapsed wall time to the remainder and split it into whole frames.
   function automatic logic [1:0] try_consume(input logic [WORD_W-1:0] elapsed,
                                              output logic [TIME_W-1:0] frames);
      logic [TIME_W-1:0] total;
      frames = '0;
      if (elapsed[WORD_W-1] || elapsed == '0) return fsfa_pkg::STS_OK;
      if (elapsed[TIME_W-1:0] > TIME_MAX - wall_rem_ns) return fsfa_pkg::STS_ACC_OVF;
      total = wall_rem_ns + elapsed[TIME_W-1:0];
      frames = total / step_ns;
      wall_rem_ns = total % step_ns;
      return fsfa_pkg::STS_OK;
   endfunction

   function automatic frame_report_type compute_frame_report(input stim_row_type r);
      frame_report_type rep;
      logic [TIME_W-1:0] frames;
      logic [TIME_W-1:0] saved_rem;
      logic [1:0] sts;
      frames = '0;
      sts = fsfa_pkg::STS_OK;
      case (r.action)
         fsfa_pkg::ACT_STEP: sts = try_advance(r.count);
         fsfa_pkg::ACT_ACCUM: begin
            saved_rem = wall_rem_ns;
            sts = try_consume(r.elapsed, frames);
            if (sts == fsfa_pkg::STS_OK) begin
               sts = try_advance({1'b0, frames});
               if (sts != fsfa_pkg::STS_OK) begin
                  wall_rem_ns = saved_rem;
                  frames = '0;
               end
            end
         end
         fsfa_pkg::ACT_CONSUME: sts = try_consume(r.elapsed, frames);
         default: begin
            frame_ctr = '0;
            sim_ns = '0;
            wall_rem_ns = '0;
            seed_val = r.seed;
         end
      endcase
      rep.frames = frames;
      rep.frame_no = frame_ctr;
      rep.sim_time = sim_ns;
      rep.remainder = wall_rem_ns;
      rep.seed = seed_val;
      rep.status = sts;
      return rep;
   endfunction

   function automatic logic [WORD_W-1:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Random requests: mostly elapsed times below five timesteps and counts up to 40, with
   // counts near the remaining room or frame overflow, fully random fields and reseeds mixed in.
   function automatic stim_row_type draw_request();
      stim_row_type r;
      int unsigned pick;
      logic [WORD_W-1:0] room;
      r = '0;
      r.count = rand64();
      r.elapsed = rand64();
      r.seed = rand64();
      pick = $urandom_range(99);
      if (pick < 8) r.action = fsfa_pkg::ACT_RESEED;
      else if (pick < 40) r.action = fsfa_pkg::ACT_ACCUM;
      else if (pick < 62) r.action = fsfa_pkg::ACT_CONSUME;
      else r.action = fsfa_pkg::ACT_STEP;
      case ($urandom_range(9))
         0: ;
         1: r.elapsed = '0;
         2: r.elapsed = {1'b0, TIME_MAX - TIME_W'($urandom_range(3))};
         3: r.elapsed = {1'b0, r.elapsed[TIME_W-1:0] >> $urandom_range(62)};
         default: r.elapsed = {1'b0, TIME_W'({1'b0, step_ns} * $urandom_range(4))
                                    + TIME_W'(rand64()) % step_ns};
      endcase
      case ($urandom_range(7))
         0: ;
         1: r.count = '0;
         2: begin
            room = {1'b0, TIME_MAX - sim_ns} / {1'b0, step_ns};
            r.count = room + WORD_W'($urandom_range(2)) - WORD_W'(1);
         end
         3: r.count = ~frame_ctr + WORD_W'($urandom_range(1));
         4: r.count = r.count >> $urandom_range(63);
         default: r.count = WORD_W'($urandom_range(40));
      endcase
      return r;
   endfunction

   task automatic log_fault(input string what);
      faults++;
      if (faults <= FAULT_PRINTS) $display("ERROR: %s", what);
   endtask

   // Present one request, wait for its transaction, then predict its response. A hand
   // typed expectation replaces the predicted one, but the predictor still advances.
   task automatic send_request(input stim_row_type r);
      frame_report_type rep;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= r.action;
      req_bus.frame_count_in <= r.count;
      req_bus.elapsed_ns <= r.elapsed;
      req_bus.new_seed <= r.seed;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      action_seen[r.action]++;
      rep = compute_frame_report(r);
      due_reports.push_back(r.typed ? r.want : rep);
   endtask

   // The timestep is only written once the block has answered every request.
   task automatic write_timestep(input logic [TIME_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (CSR_SETTLE) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.timestep_ns <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      // A write of zero is dropped by the block.
      if (value != '0) step_ns = value;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Main sequence: reset, the directed table at the reset timestep, then a random
   // phase after each timestep write. The settings run from one nanosecond to the
   // largest value, include a write of zero that must be ignored, and lower the
   // timestep from its maximum so that a large remainder gets divided.
   initial begin : stimulus
      stim_row_type r;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = fsfa_pkg::ACT_STEP;
      req_bus.frame_count_in = '0;
      req_bus.elapsed_ns = '0;
      req_bus.new_seed = '0;
      csr_bus.valid = 1'b0;
      csr_bus.timestep_ns = fsfa_pkg::TIMESTEP_RESET;
      phase_step_ns = '{63'd1, 63'd0, 63'd7, TIME_MAX, 63'd1000,
                        TIME_W'(rand64() >> $urandom_range(63)), fsfa_pkg::TIMESTEP_RESET,
                        TIME_W'($urandom_range(1, 1 << 20))};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      for (int p = 0; p < PHASES; p++) begin
         write_timestep(phase_step_ns[p]);
         steady = (p == STEADY_PHASE);
         repeat (RAND_PER_PHASE) begin
            r = draw_request();
            send_request(r);
         end
      end
      steady = 1'b0;
      req_bus.valid <= 1'b0;

      while (due_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests (step %0d, accumulate %0d, consume %0d, reseed %0d)",
               action_seen[0] + action_seen[1] + action_seen[2] + action_seen[3],
               action_seen[fsfa_pkg::ACT_STEP], action_seen[fsfa_pkg::ACT_ACCUM],
               action_seen[fsfa_pkg::ACT_CONSUME], action_seen[fsfa_pkg::ACT_RESEED]);
      $display("over %0d timestep settings; statuses ok %0d, frame %0d, sim %0d, acc %0d",
               PHASES + 1, status_seen[fsfa_pkg::STS_OK],
               status_seen[fsfa_pkg::STS_FRAME_OVF], status_seen[fsfa_pkg::STS_SIM_OVF],
               status_seen[fsfa_pkg::STS_ACC_OVF]);
      if (faults == 0) begin
         $display("fixed_step_frame_accumulator_top: match");
      end else begin
         $display("fixed_step_frame_accumulator_top: mismatch");
      end
      $finish;
   end

   // Response side: random back-pressure, and each response transaction compared with
   // the oldest expectation, field by field.
   always @(posedge clock) begin : response_check
      frame_report_type got;
      frame_report_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.frames = rsp_bus.frames_available;
         got.frame_no = rsp_bus.frame_number;
         got.sim_time = rsp_bus.sim_time_ns;
         got.remainder = rsp_bus.remainder_ns;
         got.seed = rsp_bus.seed_out;
         got.status = rsp_bus.status;
         responses_seen++;
         status_seen[got.status]++;
         if (due_reports.size() == 0) begin
            log_fault($sformatf("response %0d arrived with nothing expected", responses_seen));
         end else begin
            want = due_reports.pop_front();
            if (got.frames !== want.frames || got.frame_no !== want.frame_no
                || got.sim_time !== want.sim_time || got.remainder !== want.remainder
                || got.seed !== want.seed || got.status !== want.status) begin
               log_fault($sformatf({"response %0d\n  expected frames=%0d frame=%0d sim=%0d",
                                    " rem=%0d seed=%h status=%0d\n  actual   frames=%0d",
                                    " frame=%0d sim=%0d rem=%0d seed=%h status=%0d"},
                                   responses_seen, want.frames, want.frame_no,
                                   want.sim_time, want.remainder, want.seed, want.status,
                                   got.frames, got.frame_no, got.sim_time, got.remainder,
                                   got.seed, got.status));
            end
         end
      end
   end

   // Watchdog: ends the run when no transaction of any kind happens for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timed out after %0d cycles without a transaction", QUIET_LIMIT);
         $display("fixed_step_frame_accumulator_top: mismatch");
         $finish;
      end
   end

endmodule
